// ----- sv/pac_pkg.sv -----
// Shared widths, limits and controller/datapath handshake types for the polygon area block.
package pac_pkg;

   // Vertex coordinates, signed Q8.8
   localparam int COORD_W = 16;
   // Sum of two coordinates
   localparam int SUM_W = COORD_W + 1;
   // Edge cross product ax*by - bx*ay
   localparam int CROSS_W = 2 * COORD_W + 1;
   // Coordinate sum times cross product
   localparam int PROD_W = SUM_W + CROSS_W;

   // Result fields
   localparam int AREA_OUT_W = 39;
   localparam int CENT_W = 16;
   // Quotient bits the divider develops before saturation takes over
   localparam int QUO_W = CENT_W + 1;
   localparam int QCNT_W = $clog2(QUO_W);

   localparam int MAX_VERTICES_DEF = 64;

   localparam logic signed [63:0] AREA_OUT_MAX = 64'sd274877906943;
   localparam logic signed [63:0] AREA_OUT_MIN = -64'sd274877906944;

   localparam logic signed [CENT_W-1:0] CENT_MAX = CENT_W'(2**(CENT_W-1) - 1);
   localparam logic signed [CENT_W-1:0] CENT_MIN = CENT_W'(2**(CENT_W-1));
   localparam logic [QUO_W-1:0] QUO_POS_LIM = QUO_W'(2**(CENT_W-1) - 1);
   localparam logic [QUO_W-1:0] QUO_NEG_LIM = QUO_W'(2**(CENT_W-1));

   // Commands from the controller to the datapath
   typedef struct packed {
      logic in_ready;    // take a request this cycle if one is offered
      logic load_close;  // set up the closing edge, previous to first vertex
      logic step_a;      // product ax*by
      logic step_b;      // cross product and area accumulate
      logic step_mx;     // product (ax+bx)*c
      logic step_my;     // product (ay+by)*c, x moment accumulate
      logic acc_my;      // y moment accumulate
      logic div_load;    // start a centroid division
      logic div_step;    // one quotient bit
      logic div_save;    // store the saturated centroid
      logic sel_y;       // division works on the y moment
      logic out_load;    // load the result register and clear the polygon
   } pac_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic req_valid;
      logic req_last;
      logic edge_needed; // the offered vertex forms an edge with the previous one
      logic out_free;    // result register can take a new result
   } pac_status_type;

endpackage

// ----- sv/pac_if.sv -----
// Request and response channel interfaces of the polygon area block.
interface pac_vertex_if import pac_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic                      last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

interface pac_result_if import pac_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [AREA_OUT_W-1:0] area_doubled;
   logic signed [CENT_W-1:0]     centroid_x;
   logic signed [CENT_W-1:0]     centroid_y;
   logic                         degenerate;
   logic                         too_many;

   modport source (output valid, output area_doubled, output centroid_x, output centroid_y,
                   output degenerate, output too_many, input ready);
   modport sink   (input valid, input area_doubled, input centroid_x, input centroid_y,
                   input degenerate, input too_many, output ready);
endinterface

// ----- sv/polygon_area_centroid.sv -----
// Polygon area and centroid (shoelace): top level joining controller and datapath.
//
// Vertices arrive one request at a time in signed Q8.8 with a last flag; the
// block returns twice the signed area (Q16.16, clamped to 39 bits) and the
// centroid (Q8.8, truncated toward zero and clamped), with degenerate set for a
// zero area (centroid zero) and too_many set when vertices past MAX_VERTICES
// were dropped. One shared multiplier does four products per edge, so a vertex
// that forms an edge holds off the next request while they run; the first
// vertex of a polygon does not. The last vertex adds the closing edge, then the
// two 17-step restoring divisions and the load of the result register, which
// waits until that register is free. The result register holds a response
// while the next polygon's vertices are already being taken.
module polygon_area_centroid import pac_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pac_vertex_if.sink    req,
   pac_result_if.source  rsp
);

   pac_cmd_type    cmd;
   pac_status_type status;

   pac_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   pac_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// ----- sv/pac_datapath.sv -----
// Datapath: vertex registers, shared multiplier, shoelace sums, divider, result register.
module pac_datapath import pac_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   pac_vertex_if.sink       req,
   pac_result_if.source     rsp,
   input  pac_cmd_type      cmd,
   output pac_status_type   status
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int AREA_W = CROSS_W + $clog2(MAX_VERTICES) + 1;
   localparam int MOM_W  = PROD_W + $clog2(MAX_VERTICES) + 1;
   localparam int DEN_W  = AREA_W + 2;
   localparam int REM_W  = (MOM_W > DEN_W + QUO_W) ? MOM_W : DEN_W + QUO_W;

   // Polygon state
   logic signed [COORD_W-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      ovf_ff;
   logic signed [AREA_W-1:0]  area_ff;
   logic signed [MOM_W-1:0]   mom_x_ff, mom_y_ff;

   // Edge operands and multiplier results
   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [CROSS_W-1:0] c_ff;

   // Divider
   logic [REM_W-1:0]          rem_ff, dsh_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic                      sat_ff, neg_ff;
   logic signed [CENT_W-1:0]  cx_ff, cy_ff;

   // Result register
   logic                         rsp_valid_ff;
   logic signed [AREA_OUT_W-1:0] rsp_area_ff;
   logic signed [CENT_W-1:0]     rsp_cx_ff, rsp_cy_ff;
   logic                         rsp_degen_ff, rsp_many_ff;

   logic                      accept;
   logic                      keep;
   logic signed [SUM_W-1:0]   mul_a;
   logic signed [CROSS_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_out;
   logic signed [CROSS_W-1:0] cross_in;
   logic [MOM_W-1:0]          mom_sel, num_mag;
   logic                      num_neg, area_neg, area_zero;
   logic [AREA_W-1:0]         area_mag;
   logic [DEN_W-1:0]          den_mag;
   logic                      sat_in;
   logic signed [CENT_W-1:0]  cent_val;
   logic signed [63:0]        area_wide, area_sat;

   assign accept = cmd.in_ready && req.valid;
   assign keep   = count_ff < CNT_W'(MAX_VERTICES);

   assign req.ready          = cmd.in_ready;
   assign status.req_valid   = req.valid;
   assign status.req_last    = req.last_vertex;
   assign status.edge_needed = (count_ff != '0) && keep;
   assign status.out_free    = !rsp_valid_ff || rsp.ready;

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.step_a) begin
         mul_a = SUM_W'(ax_ff);
         mul_b = CROSS_W'(by_ff);
      end else if (cmd.step_b) begin
         mul_a = SUM_W'(bx_ff);
         mul_b = CROSS_W'(ay_ff);
      end else if (cmd.step_mx) begin
         mul_a = SUM_W'(ax_ff) + SUM_W'(bx_ff);
         mul_b = c_ff;
      end else if (cmd.step_my) begin
         mul_a = SUM_W'(ay_ff) + SUM_W'(by_ff);
         mul_b = c_ff;
      end
   end

   assign mul_out  = mul_a * mul_b;
   assign cross_in = CROSS_W'(prod_ff) - CROSS_W'(mul_out);

   // Vertex capture and edge operands
   always_ff @(posedge clock) begin
      if (accept) begin
         if (keep && count_ff == '0) begin
            first_x_ff <= req.vertex_x;
            first_y_ff <= req.vertex_y;
         end
         if (keep) begin
            prev_x_ff <= req.vertex_x;
            prev_y_ff <= req.vertex_y;
         end
         ax_ff <= prev_x_ff;
         ay_ff <= prev_y_ff;
         bx_ff <= req.vertex_x;
         by_ff <= req.vertex_y;
      end else if (cmd.load_close) begin
         ax_ff <= prev_x_ff;
         ay_ff <= prev_y_ff;
         bx_ff <= first_x_ff;
         by_ff <= first_y_ff;
      end
      if (cmd.step_a || cmd.step_mx || cmd.step_my) begin
         prod_ff <= mul_out;
      end
      if (cmd.step_b) begin
         c_ff <= cross_in;
      end
   end

   // Running sums, vertex count and overflow flag
   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         area_ff  <= '0;
         mom_x_ff <= '0;
         mom_y_ff <= '0;
      end else begin
         if (accept) begin
            if (keep) begin
               count_ff <= count_ff + CNT_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.step_b) begin
            area_ff <= area_ff + AREA_W'(cross_in);
         end
         if (cmd.step_my) begin
            mom_x_ff <= mom_x_ff + MOM_W'(prod_ff);
         end
         if (cmd.acc_my) begin
            mom_y_ff <= mom_y_ff + MOM_W'(prod_ff);
         end
      end
   end

   // Divider operands: magnitudes of moment and of three times the area
   assign mom_sel   = cmd.sel_y ? $unsigned(mom_y_ff) : $unsigned(mom_x_ff);
   assign num_neg   = mom_sel[MOM_W-1];
   assign num_mag   = num_neg ? (MOM_W'(0) - mom_sel) : mom_sel;
   assign area_neg  = area_ff[AREA_W-1];
   assign area_mag  = area_neg ? (AREA_W'(0) - $unsigned(area_ff)) : $unsigned(area_ff);
   assign area_zero = (area_ff == '0);
   assign den_mag   = {2'b00, area_mag} + {1'b0, area_mag, 1'b0};
   assign sat_in    = REM_W'(num_mag) >= (REM_W'(den_mag) << QUO_W);

   // Restoring division, one quotient bit per step
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= REM_W'(num_mag);
         dsh_ff <= REM_W'(den_mag) << (QUO_W - 1);
         quo_ff <= '0;
         sat_ff <= sat_in;
         neg_ff <= num_neg ^ area_neg;
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   // Signed, saturated centroid coordinate
   always_comb begin
      if (area_zero) begin
         cent_val = '0;
      end else if (sat_ff) begin
         cent_val = neg_ff ? CENT_MIN : CENT_MAX;
      end else if (neg_ff) begin
         cent_val = (quo_ff > QUO_NEG_LIM) ? CENT_MIN : CENT_W'(QUO_W'(0) - quo_ff);
      end else begin
         cent_val = (quo_ff > QUO_POS_LIM) ? CENT_MAX : CENT_W'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_save) begin
         if (cmd.sel_y) begin
            cy_ff <= cent_val;
         end else begin
            cx_ff <= cent_val;
         end
      end
   end

   // Doubled area clamped to the output range
   always_comb begin
      area_wide = 64'(area_ff);
      if (area_wide > AREA_OUT_MAX) begin
         area_sat = AREA_OUT_MAX;
      end else if (area_wide < AREA_OUT_MIN) begin
         area_sat = AREA_OUT_MIN;
      end else begin
         area_sat = area_wide;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_area_ff  <= area_sat[AREA_OUT_W-1:0];
         rsp_cx_ff    <= cx_ff;
         rsp_cy_ff    <= cy_ff;
         rsp_degen_ff <= area_zero;
         rsp_many_ff  <= ovf_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.area_doubled = rsp_area_ff;
   assign rsp.centroid_x   = rsp_cx_ff;
   assign rsp.centroid_y   = rsp_cy_ff;
   assign rsp.degenerate   = rsp_degen_ff;
   assign rsp.too_many     = rsp_many_ff;

endmodule

// ----- sv/pac_ctrl.sv -----
// Controller: sequences edge products, the closing edge, both divisions and the result load.
module pac_ctrl import pac_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  pac_status_type status,
   output pac_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_EDGE_A   = 10'b00_0000_0010,
      ST_EDGE_B   = 10'b00_0000_0100,
      ST_EDGE_MX  = 10'b00_0000_1000,
      ST_EDGE_MY  = 10'b00_0001_0000,
      ST_CLOSE    = 10'b00_0010_0000,
      ST_DIV_LOAD = 10'b00_0100_0000,
      ST_DIV_STEP = 10'b00_1000_0000,
      ST_DIV_SAVE = 10'b01_0000_0000,
      ST_FINISH   = 10'b10_0000_0000
   } pac_state_type;

   pac_state_type     state_ff, state_in;
   logic              last_ff, last_in;
   logic              close_ff, close_in;
   logic              sel_y_ff, sel_y_in;
   logic              acc_my_ff;
   logic [QCNT_W-1:0] qcnt_ff, qcnt_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      close_in = close_ff;
      sel_y_in = sel_y_ff;
      qcnt_in  = qcnt_ff;
      cmd      = '0;
      cmd.sel_y  = sel_y_ff;
      cmd.acc_my = acc_my_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.req_valid) begin
               last_in  = status.req_last;
               close_in = 1'b0;
               if (status.edge_needed) begin
                  state_in = ST_EDGE_A;
               end else if (status.req_last) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_EDGE_A: begin
            cmd.step_a = 1'b1;
            state_in   = ST_EDGE_B;
         end
         ST_EDGE_B: begin
            cmd.step_b = 1'b1;
            state_in   = ST_EDGE_MX;
         end
         ST_EDGE_MX: begin
            cmd.step_mx = 1'b1;
            state_in    = ST_EDGE_MY;
         end
         ST_EDGE_MY: begin
            cmd.step_my = 1'b1;
            if (close_ff) begin
               sel_y_in = 1'b0;
               state_in = ST_DIV_LOAD;
            end else if (last_ff) begin
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CLOSE: begin
            cmd.load_close = 1'b1;
            close_in       = 1'b1;
            state_in       = ST_EDGE_A;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            qcnt_in      = QCNT_W'(QUO_W - 1);
            state_in     = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (qcnt_ff == '0) begin
               state_in = ST_DIV_SAVE;
            end else begin
               qcnt_in = qcnt_ff - QCNT_W'(1);
            end
         end
         ST_DIV_SAVE: begin
            cmd.div_save = 1'b1;
            if (sel_y_ff) begin
               state_in = ST_FINISH;
            end else begin
               sel_y_in = 1'b1;
               state_in = ST_DIV_LOAD;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         last_ff   <= 1'b0;
         close_ff  <= 1'b0;
         sel_y_ff  <= 1'b0;
         acc_my_ff <= 1'b0;
         qcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         last_ff   <= last_in;
         close_ff  <= close_in;
         sel_y_ff  <= sel_y_in;
         acc_my_ff <= (state_ff == ST_EDGE_MY);
         qcnt_ff   <= qcnt_in;
      end
   end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the shoelace polygon area and centroid block: directed and random polygons.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pac_pkg::*;

   typedef struct packed {
      logic signed [AREA_OUT_W-1:0] area_doubled;
      logic signed [CENT_W-1:0]     centroid_x;
      logic signed [CENT_W-1:0]     centroid_y;
      logic                         degenerate;
      logic                         too_many;
   } shape_result_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last_vertex;
      logic                      typed;   // use the result below instead of the predictor
      shape_result_type          want;
   } vertex_row_type;

   localparam shape_result_type NOT_TYPED  = '0;
   // zero area: centroid forced to zero
   localparam shape_result_type FLAT_SHAPE = '{39'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0};
   localparam int               DIR_ROWS   = 25;
   localparam int               RANDOM_VERTICES = 550;

   // Directed polygons
   localparam vertex_row_type dir_rows [DIR_ROWS] = '{
      // single vertex at the origin, right after reset
      '{16'sd0,     16'sd0,     1'b1, 1'b1, FLAT_SHAPE},
      // single vertex at the coordinate extremes
      '{16'sd32767, 16'sh8000,  1'b1, 1'b1, FLAT_SHAPE},
      // right triangle on the positive extremes
      '{16'sd0,     16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sd32767, 16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sd0,     16'sd32767, 1'b1, 1'b1,
        '{39'sd1073676289, 16'sd10922, 16'sd10922, 1'b0, 1'b0}},
      // right triangle on the negative extremes
      '{16'sd0,     16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sh8000,  16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sd0,     16'sh8000,  1'b1, 1'b1,
        '{39'sd1073741824, -16'sd10922, -16'sd10922, 1'b0, 1'b0}},
      // two vertices: the closing edge cancels the only edge
      '{16'sd100,   16'sd200,   1'b0, 1'b0, NOT_TYPED},
      '{-16'sd300,  16'sd50,    1'b1, 1'b1, FLAT_SHAPE},
      // collinear points
      '{16'sd0,     16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sd256,   16'sd256,   1'b0, 1'b0, NOT_TYPED},
      '{16'sd512,   16'sd512,   1'b1, 1'b1, FLAT_SHAPE},
      // unit square, counterclockwise
      '{16'sd0,     16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sd256,   16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sd256,   16'sd256,   1'b0, 1'b0, NOT_TYPED},
      '{16'sd0,     16'sd256,   1'b1, 1'b1, '{39'sd131072, 16'sd128, 16'sd128, 1'b0, 1'b0}},
      // bow tie across the full range
      '{16'sh8000,  16'sh8000,  1'b0, 1'b0, NOT_TYPED},
      '{16'sd32767, 16'sd32767, 1'b0, 1'b0, NOT_TYPED},
      '{16'sd32767, 16'sh8000,  1'b0, 1'b0, NOT_TYPED},
      '{16'sh8000,  16'sd32767, 1'b1, 1'b0, NOT_TYPED},
      // clockwise square in the negative quadrant
      '{-16'sd256,  -16'sd256,  1'b0, 1'b0, NOT_TYPED},
      '{-16'sd256,  16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sd0,     16'sd0,     1'b0, 1'b0, NOT_TYPED},
      '{16'sd0,     -16'sd256,  1'b1, 1'b0, NOT_TYPED}
   };

   logic clock;
   logic reset;

   pac_vertex_if req_if ();
   pac_result_if rsp_if ();

   polygon_area_centroid u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   shape_result_type shape_results_due[$];
   int               error_count;
   int               accepted_vertices;
   int               send_idle_pct;
   int               rsp_stall_pct;

   // Shoelace predictor state
   longint first_x, first_y, prev_x, prev_y;
   longint area_acc, moment_x_acc, moment_y_acc;
   int     held_vertices;
   bit     dropped_seen;

   // Append one expected result to the scoreboard
   function automatic void expect_shape(input shape_result_type res);
      shape_results_due = {shape_results_due, res};
   endfunction

   // One edge: cross product into the area, weighted into both moments
   task automatic shoelace_edge(input longint ax, ay, bx, by);
      longint c;
      c = ax * by - bx * ay;
      area_acc     += c;
      moment_x_acc += (ax + bx) * c;
      moment_y_acc += (ay + by) * c;
   endtask

   // Quotient truncated toward zero, then clamped to Q8.8
   function automatic logic signed [CENT_W-1:0] centroid_q(input longint moment, den);
      longint q;
      q = moment / den;
      if (q > 32767)
         q = 32767;
      if (q < -32768)
         q = -32768;
      return q[CENT_W-1:0];
   endfunction

   // Take one vertex; on the last one close the polygon and give its result
   task automatic shoelace_take(input logic signed [COORD_W-1:0] x, y, input logic last_v,
                                output bit closes, output shape_result_type res);
      longint vx, vy, a_out;
      vx = x;
      vy = y;
      if (held_vertices < MAX_VERTICES_DEF) begin
         if (held_vertices == 0) begin
            first_x = vx;
            first_y = vy;
         end else begin
            shoelace_edge(prev_x, prev_y, vx, vy);
         end
         prev_x = vx;
         prev_y = vy;
         held_vertices++;
      end else begin
         dropped_seen = 1'b1;
      end
      closes = last_v;
      res = '0;
      if (last_v) begin
         shoelace_edge(prev_x, prev_y, first_x, first_y);
         res.degenerate = (area_acc == 0);
         if (!res.degenerate) begin
            res.centroid_x = centroid_q(moment_x_acc, area_acc * 3);
            res.centroid_y = centroid_q(moment_y_acc, area_acc * 3);
         end
         a_out = area_acc;
         if (a_out > AREA_OUT_MAX)
            a_out = AREA_OUT_MAX;
         if (a_out < AREA_OUT_MIN)
            a_out = AREA_OUT_MIN;
         res.area_doubled = a_out[AREA_OUT_W-1:0];
         res.too_many = dropped_seen;
         first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
         area_acc = 0; moment_x_acc = 0; moment_y_acc = 0;
         held_vertices = 0;
         dropped_seen = 1'b0;
      end
   endtask

   // Offer one vertex request and wait until it is taken
   task automatic present(input logic signed [COORD_W-1:0] x, y, input logic last_v);
      if (accepted_vertices < 200) begin
         send_idle_pct = 10;
         rsp_stall_pct = 61;
      end else if (accepted_vertices < 400) begin
         send_idle_pct = 61;
         rsp_stall_pct = 10;
      end else begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.vertex_x    <= x;
      req_if.vertex_y    <= y;
      req_if.last_vertex <= last_v;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      accepted_vertices++;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !reset && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin : check_results
      shape_result_type seen;
      shape_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen = '{rsp_if.area_doubled, rsp_if.centroid_x, rsp_if.centroid_y,
                  rsp_if.degenerate, rsp_if.too_many};
         if (shape_results_due.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: result with no polygon pending: area %0d cx %0d cy %0d",
                        $realtime, seen.area_doubled, seen.centroid_x, seen.centroid_y);
         end else begin
            want = shape_results_due.pop_front();
            if (seen.area_doubled !== want.area_doubled ||
                seen.centroid_x !== want.centroid_x ||
                seen.centroid_y !== want.centroid_y ||
                seen.degenerate !== want.degenerate ||
                seen.too_many !== want.too_many) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: mismatch (expected/actual) area %0d/%0d cx %0d/%0d cy %0d/%0d",
                           $realtime, want.area_doubled, seen.area_doubled,
                           want.centroid_x, seen.centroid_x, want.centroid_y,
                           seen.centroid_y);
                  $display("   degenerate %0b/%0b too_many %0b/%0b",
                           want.degenerate, seen.degenerate, want.too_many, seen.too_many);
               end
            end
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      int                        i, size, kind, poly_idx, random_vertices;
      int                        base_x, base_y, dir_x, dir_y;
      logic signed [COORD_W-1:0] vx, vy;
      bit                        closes;
      shape_result_type          pred;

      error_count = 0;
      accepted_vertices = 0;
      send_idle_pct = 10;
      rsp_stall_pct = 61;
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      area_acc = 0; moment_x_acc = 0; moment_y_acc = 0;
      held_vertices = 0;
      dropped_seen = 1'b0;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.vertex_x = '0;
      req_if.vertex_y = '0;
      req_if.last_vertex = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (i = 0; i < DIR_ROWS; i++) begin
         present(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last_vertex);
         shoelace_take(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last_vertex, closes, pred);
         if (closes)
            expect_shape(dir_rows[i].typed ? dir_rows[i].want : pred);
      end

      // Random polygons
      poly_idx = 0;
      random_vertices = 0;
      while (random_vertices < RANDOM_VERTICES) begin
         poly_idx++;
         kind = $urandom_range(0, 99);
         if (poly_idx % 30 == 9)
            size = $urandom_range(MAX_VERTICES_DEF + 1, MAX_VERTICES_DEF + 6);
         else if (poly_idx % 30 == 24)
            size = MAX_VERTICES_DEF;
         else if (kind < 10)
            size = $urandom_range(1, 2);
         else if (kind < 25)
            size = $urandom_range(3, 8);
         else
            size = $urandom_range(3, 12);
         base_x = $urandom_range(0, 8191) - 4096;
         base_y = $urandom_range(0, 8191) - 4096;
         dir_x  = $urandom_range(0, 127) - 64;
         dir_y  = $urandom_range(0, 127) - 64;
         for (i = 0; i < size; i++) begin
            if (kind >= 10 && kind < 20) begin
               // points on one line
               vx = COORD_W'(base_x + i * dir_x);
               vy = COORD_W'(base_y + i * dir_y);
            end else if (kind >= 20 && kind < 25) begin
               // one point repeated
               vx = COORD_W'(base_x);
               vy = COORD_W'(base_y);
            end else if (kind >= 25 && kind < 60) begin
               vx = COORD_W'(base_x + int'($urandom_range(0, 1023)) - 512);
               vy = COORD_W'(base_y + int'($urandom_range(0, 1023)) - 512);
            end else begin
               vx = COORD_W'($urandom);
               vy = COORD_W'($urandom);
            end
            present(vx, vy, i == size - 1);
            shoelace_take(vx, vy, i == size - 1, closes, pred);
            if (closes)
               expect_shape(pred);
            if (i < MAX_VERTICES_DEF)
               random_vertices++;
         end
      end
      req_if.valid <= 1'b0;

      // Drain outstanding results
      while (shape_results_due.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Run limit
   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/pac_pkg.sv
sv/pac_if.sv
sv/pac_datapath.sv
sv/pac_ctrl.sv
sv/polygon_area_centroid.sv
dv/tb_top.sv
